>>> rtl/core/spf_pkg.sv
`default_nettype none

package spf_pkg;

   localparam int NUM_W  = 12;
   localparam int EXP_W  = 4;
   localparam int DCNT_W = $clog2(NUM_W);
   localparam int LIM_W  = 17;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_SIEVE_RD,
      ST_SIEVE_CHK,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_IDLE,
      ST_Q_RD,
      ST_Q_CHK,
      ST_DIV,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/spf_ram.sv
`default_nettype none

module spf_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/spf_sieve_factorizer_top.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_number
// rsp       out        rsp_valid/rsp_stall   rsp_prime_factor, rsp_exponent, rsp_last,
//                                            rsp_empty_res
//
// After reset the table is cleared and then sieved; req_stall stays high meanwhile.
// Each division of a query is done by the restoring divider (one quotient bit a cycle)
// after a table read of the remaining value.
// An input of 0, 1 or not below TABLE_SIZE gives one empty item.
// A stalled result waits in the output register; the sequencer holds until it drains.
`default_nettype none

module spf_sieve_factorizer_top #(
   parameter int TABLE_SIZE = 4096
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [spf_pkg::NUM_W-1:0]   req_number,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [spf_pkg::NUM_W-1:0]   rsp_prime_factor,
   output logic      [spf_pkg::EXP_W-1:0]   rsp_exponent,
   output logic                             rsp_last,
   output logic                             rsp_empty_res
);

   import spf_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_SIZE);
   localparam logic [ADDR_W:0]    TS_Q    = (ADDR_W+1)'(TABLE_SIZE);
   localparam logic [ADDR_W-1:0]  LAST_IX = ADDR_W'(TABLE_SIZE - 1);
   localparam logic [LIM_W-1:0]   TS_LIM  = LIM_W'(TABLE_SIZE);
   localparam logic [DCNT_W-1:0]  DIV_END = DCNT_W'(NUM_W - 1);

   state_type state_ff, state_in;

   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [ADDR_W-1:0] p_ff, p_in;
   logic [ADDR_W-1:0] q_ff, q_in;
   logic [NUM_W-1:0]  rem_val_ff, rem_val_in;
   logic [NUM_W-1:0]  cur_p_ff, cur_p_in;
   logic [EXP_W-1:0]  expo_ff, expo_in;
   logic [NUM_W-1:0]  div_rem_ff, div_rem_in;
   logic [NUM_W-1:0]  div_quo_ff, div_quo_in;
   logic [DCNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic              last_pend_ff, last_pend_in;
   logic              empty_pend_ff, empty_pend_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [NUM_W-1:0]  rsp_prime_ff;
   logic [EXP_W-1:0]  rsp_expo_ff;
   logic              rsp_last_ff;
   logic              rsp_empty_ff;

   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [ADDR_W-1:0] mem_wr_data;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [ADDR_W-1:0] mem_rd_data;

   logic              req_take;
   logic              rsp_load;
   logic              out_free;
   logic              num_empty;
   logic [ADDR_W:0]   q_first;
   logic [ADDR_W:0]   q_next;
   logic [NUM_W-1:0]  factor;
   logic              same_prime;
   logic [NUM_W:0]    div_trial;
   logic              div_fit;
   logic [NUM_W-1:0]  div_rem_step;
   logic [NUM_W-1:0]  div_quo_step;

   spf_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign num_empty = (req_number < NUM_W'(2)) ||
                      ({{(LIM_W-NUM_W){1'b0}}, req_number} >= TS_LIM);
   assign q_first   = {p_ff, 1'b0};
   assign q_next    = {1'b0, q_ff} + {1'b0, p_ff};

   // A zero entry for a number of two or more means it was never marked: it is prime.
   assign factor     = (mem_rd_data == '0) ? rem_val_ff : NUM_W'(mem_rd_data);
   assign same_prime = (expo_ff == '0) || (factor == cur_p_ff);

   // One step of the restoring divider.
   assign div_trial    = {div_rem_ff, div_quo_ff[NUM_W-1]};
   assign div_fit      = div_trial >= {1'b0, cur_p_ff};
   assign div_rem_step = div_fit ? NUM_W'(div_trial - {1'b0, cur_p_ff})
                                 : div_trial[NUM_W-1:0];
   assign div_quo_step = {div_quo_ff[NUM_W-2:0], div_fit};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_IX) begin
               state_in = ST_SIEVE_RD;
            end
         end
         ST_SIEVE_RD: begin
            state_in = (q_first >= TS_Q) ? ST_IDLE : ST_SIEVE_CHK;
         end
         ST_SIEVE_CHK: begin
            state_in = (mem_rd_data == '0) ? ST_MARK_RD : ST_SIEVE_RD;
         end
         ST_MARK_RD: begin
            state_in = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            state_in = (q_next >= TS_Q) ? ST_SIEVE_RD : ST_MARK_RD;
         end
         ST_IDLE: begin
            if (req_take) begin
               state_in = num_empty ? ST_EMIT : ST_Q_RD;
            end
         end
         ST_Q_RD: begin
            state_in = (rem_val_ff == NUM_W'(1)) ? ST_EMIT : ST_Q_CHK;
         end
         ST_Q_CHK: begin
            state_in = same_prime ? ST_DIV : ST_EMIT;
         end
         ST_DIV: begin
            if (div_cnt_ff == DIV_END) begin
               state_in = ST_Q_RD;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = last_pend_ff ? ST_IDLE : ST_Q_RD;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_stall   = 1'b1;
      mem_wr_en   = 1'b0;
      mem_wr_addr = q_ff;
      mem_wr_data = p_ff;
      mem_rd_addr = p_ff;
      rsp_load    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
         end
         ST_MARK_RD: begin
            mem_rd_addr = q_ff;
         end
         ST_MARK_WR: begin
            mem_wr_en = (mem_rd_data == '0);
         end
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_Q_RD: begin
            mem_rd_addr = ADDR_W'(rem_val_ff);
         end
         ST_EMIT: begin
            rsp_load = out_free;
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      clr_in        = clr_ff;
      p_in          = p_ff;
      q_in          = q_ff;
      rem_val_in    = rem_val_ff;
      cur_p_in      = cur_p_ff;
      expo_in       = expo_ff;
      div_rem_in    = div_rem_ff;
      div_quo_in    = div_quo_ff;
      div_cnt_in    = div_cnt_ff;
      last_pend_in  = last_pend_ff;
      empty_pend_in = empty_pend_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            p_in   = ADDR_W'(2);
         end
         ST_SIEVE_CHK: begin
            if (mem_rd_data == '0) begin
               q_in = q_first[ADDR_W-1:0];
            end else begin
               p_in = p_ff + ADDR_W'(1);
            end
         end
         ST_MARK_WR: begin
            if (q_next >= TS_Q) begin
               p_in = p_ff + ADDR_W'(1);
            end else begin
               q_in = q_next[ADDR_W-1:0];
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               expo_in       = '0;
               cur_p_in      = '0;
               rem_val_in    = num_empty ? '0 : req_number;
               last_pend_in  = num_empty;
               empty_pend_in = num_empty;
            end
         end
         ST_Q_RD: begin
            last_pend_in = (rem_val_ff == NUM_W'(1));
         end
         ST_Q_CHK: begin
            if (same_prime) begin
               cur_p_in   = factor;
               div_rem_in = '0;
               div_quo_in = rem_val_ff;
               div_cnt_in = '0;
            end
         end
         ST_DIV: begin
            div_rem_in = div_rem_step;
            div_quo_in = div_quo_step;
            div_cnt_in = div_cnt_ff + DCNT_W'(1);
            if (div_cnt_ff == DIV_END) begin
               rem_val_in = div_quo_step;
               expo_in    = expo_ff + EXP_W'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               expo_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff          <= p_in;
      q_ff          <= q_in;
      rem_val_ff    <= rem_val_in;
      cur_p_ff      <= cur_p_in;
      expo_ff       <= expo_in;
      div_rem_ff    <= div_rem_in;
      div_quo_ff    <= div_quo_in;
      div_cnt_ff    <= div_cnt_in;
      last_pend_ff  <= last_pend_in;
      empty_pend_ff <= empty_pend_in;
      if (rsp_load) begin
         rsp_prime_ff <= cur_p_ff;
         rsp_expo_ff  <= expo_ff;
         rsp_last_ff  <= last_pend_ff;
         rsp_empty_ff <= empty_pend_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_prime_factor = rsp_prime_ff;
   assign rsp_exponent     = rsp_expo_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_empty_res    = rsp_empty_ff;

endmodule

`default_nettype wire

>>> rtl/core/spf_checker.sv
`default_nettype none

module spf_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_stall,
   input wire logic [spf_pkg::NUM_W-1:0]  req_number,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic [spf_pkg::NUM_W-1:0]  rsp_prime_factor,
   input wire logic [spf_pkg::EXP_W-1:0]  rsp_exponent,
   input wire logic                       rsp_last,
   input wire logic                       rsp_empty_res
);

   import spf_pkg::*;

   // The table is cleared and sieved after reset, so no item can enter right away.
   a_busy_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_stall)
      else $error("request taken right after reset");

   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |->
         rsp_last && (rsp_prime_factor == '0) && (rsp_exponent == '0))
      else $error("empty result malformed");

   a_factor_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_empty_res |->
         (rsp_exponent != '0) && (rsp_prime_factor >= NUM_W'(2)))
      else $error("factor result malformed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_prime_factor) &&
         $stable(rsp_exponent) && $stable(rsp_last) && $stable(rsp_empty_res))
      else $error("stalled result changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_number))
      else $error("stalled request changed");

endmodule

bind spf_sieve_factorizer_top spf_checker u_spf_checker (.*);

`default_nettype wire
